// ===== sv/irt_pkg.sv =====
// Shared constants, types and helper functions for the integer to radix text converter.
package irt_pkg;

  parameter int VALUE_BITS_DEF = 32;
  // Quotient bits resolved per divider cycle
  parameter int BITS_PER_CYCLE = 8;

  parameter int RADIX_W = 6;
  parameter int CHAR_W  = 8;

  parameter logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  parameter logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  parameter logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  parameter logic [CHAR_W-1:0] CHAR_ZERO     = 8'h30;
  parameter logic [CHAR_W-1:0] CHAR_LETTER_A = 8'h61;
  parameter logic [CHAR_W-1:0] CHAR_MINUS    = 8'h2d;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_PRIME,
    ST_SIGN,
    ST_SEND
  } irt_state_t;

  typedef struct packed {
    logic start;       // capture input value
    logic divide;      // one divider step
    logic prime;       // first buffer read, most significant digit
    logic emit_sign;   // load '-' into output register
    logic emit_digit;  // load current digit, fetch next one
  } irt_cmd_t;

  typedef struct packed {
    logic div_done;    // final divider cycle with zero quotient
    logic negative;
    logic more;        // digits left below the current one
    logic out_free;    // output register can take a character
  } irt_status_t;

  function automatic logic [RADIX_W-1:0] sat_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    else if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d <= 6'd9) c = CHAR_ZERO + CHAR_W'(d);
    else c = CHAR_LETTER_A + CHAR_W'(d) - 8'd10;
    return c;
  endfunction

endpackage

// ===== sv/irt_if.sv =====
// Valid/ready channel interfaces for input numbers, output characters and radix writes.
interface irt_value_if #(parameter int VALUE_BITS = irt_pkg::VALUE_BITS_DEF) ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface irt_text_if ();
  import irt_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] text_char;
  logic              last_char;
  modport source (output valid, output text_char, output last_char, input ready);
  modport sink (input valid, input text_char, input last_char, output ready);
endinterface

interface irt_cfg_if ();
  import irt_pkg::*;
  logic               valid;
  logic               ready;
  logic [RADIX_W-1:0] radix;
  modport source (output valid, output radix, input ready);
  modport sink (input valid, input radix, output ready);
endinterface

// ===== sv/integer_to_radix_text.sv =====
// Top level: signed integer to ASCII text in a configurable base.
//
//  channel  dir   payload                   transaction
//  number   in    value[VALUE_BITS-1:0]     one integer to convert
//  cfg      in    radix[5:0]                radix write, always ready
//  text     out   text_char[7:0], last_char one character, last flags end
//
// A number is accepted while idle, then the divider does a full division of the
// quotient for each of its D digits (8 quotient bits per cycle), the digit
// buffer is primed, and the characters ('-' plus D digits) are sent in turn.
// Reset: radix 10, idle, output empty; the digit buffer needs no clearing.
// A stalled text channel holds the character and pauses the emit sequence.
module integer_to_radix_text #(
  parameter int VALUE_BITS = irt_pkg::VALUE_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  irt_value_if.sink   number,
  irt_cfg_if.sink     cfg,
  irt_text_if.source  text
);
  import irt_pkg::*;

  irt_cmd_t    cmd;
  irt_status_t status;

  assign cfg.ready = 1'b1;

  irt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (number.valid),
    .in_ready (number.ready),
    .status   (status),
    .cmd      (cmd)
  );

  irt_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .value     (number.value),
    .cfg_valid (cfg.valid),
    .cfg_radix (cfg.radix),
    .cmd       (cmd),
    .status    (status),
    .out_valid (text.valid),
    .out_ready (text.ready),
    .text_char (text.text_char),
    .last_char (text.last_char)
  );

endmodule

// ===== sv/irt_ctrl.sv =====
// Sequencing state machine: capture, divide, prime, then emit sign (if negative) and digits.
module irt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  irt_pkg::irt_status_t status,
  output irt_pkg::irt_cmd_t    cmd
);
  import irt_pkg::*;

  irt_state_t state;
  irt_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_DIVIDE;
      ST_DIVIDE: if (status.div_done) state_next = ST_PRIME;
      ST_PRIME:  state_next = status.negative ? ST_SIGN : ST_SEND;
      ST_SIGN:   if (status.out_free) state_next = ST_SEND;
      ST_SEND:   if (status.out_free && !status.more) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      ST_DIVIDE: cmd.divide = 1'b1;
      ST_PRIME:  cmd.prime = 1'b1;
      ST_SIGN:   cmd.emit_sign = status.out_free;
      ST_SEND:   cmd.emit_digit = status.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== sv/irt_datapath.sv =====
// Radix register, 8-bit-per-cycle divider, digit buffer and output register.
module irt_datapath #(
  parameter int VALUE_BITS = irt_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic signed [VALUE_BITS-1:0] value,
  input  logic                         cfg_valid,
  input  logic [irt_pkg::RADIX_W-1:0]  cfg_radix,
  input  irt_pkg::irt_cmd_t            cmd,
  output irt_pkg::irt_status_t         status,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [irt_pkg::CHAR_W-1:0]   text_char,
  output logic                         last_char
);
  import irt_pkg::*;

  localparam int STEPS = (VALUE_BITS + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
  localparam int PW    = STEPS * BITS_PER_CYCLE;
  localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int AW    = $clog2(VALUE_BITS);
  localparam int CW    = $clog2(VALUE_BITS + 1);

  logic [RADIX_W-1:0]    radix;
  logic [PW-1:0]         quo;
  logic [RADIX_W-1:0]    rem;
  logic [SW-1:0]         step;
  logic                  neg;
  logic [CW-1:0]         cnt;
  logic [AW-1:0]         rd_ptr;
  logic [RADIX_W-1:0]    digit_q;
  logic [RADIX_W-1:0]    mem [VALUE_BITS];

  logic [VALUE_BITS-1:0] v_u;
  logic [VALUE_BITS-1:0] mag;
  logic [PW-1:0]         quo_w;
  logic [RADIX_W-1:0]    rem_w;
  logic [RADIX_W:0]      trial;
  logic                  last_step;
  logic                  wr_en;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  load_out;

  assign v_u = value;
  assign mag = v_u[VALUE_BITS-1] ? (~v_u + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : v_u;

  always_ff @(posedge clk) begin
    if (rst) radix <= RADIX_RESET;
    else if (cfg_valid) radix <= sat_radix(cfg_radix);
  end

  // Restoring division, BITS_PER_CYCLE quotient bits per cycle
  always_comb begin
    rem_w = rem;
    quo_w = quo;
    trial = '0;
    for (int i = 0; i < BITS_PER_CYCLE; i++) begin
      trial = {rem_w, quo_w[PW-1]};
      quo_w = {quo_w[PW-2:0], 1'b0};
      if (trial >= {1'b0, radix}) begin
        rem_w    = RADIX_W'(trial - {1'b0, radix});
        quo_w[0] = 1'b1;
      end else begin
        rem_w = trial[RADIX_W-1:0];
      end
    end
  end

  assign last_step = (step == SW'(STEPS - 1));
  assign wr_en     = cmd.divide && last_step;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      quo  <= PW'(mag);
      rem  <= '0;
      step <= '0;
      cnt  <= '0;
      neg  <= v_u[VALUE_BITS-1];
    end else if (cmd.divide) begin
      quo <= quo_w;
      if (last_step) begin
        rem  <= '0;
        step <= '0;
        cnt  <= cnt + CW'(1);
      end else begin
        rem  <= rem_w;
        step <= step + SW'(1);
      end
    end
  end

  // Digit buffer, least significant digit written first
  always_ff @(posedge clk) begin
    if (wr_en) mem[cnt[AW-1:0]] <= rem_w;
  end

  assign rd_en   = cmd.prime || (cmd.emit_digit && (rd_ptr != '0));
  assign rd_addr = cmd.prime ? AW'(cnt - CW'(1)) : rd_ptr - AW'(1);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      digit_q <= mem[rd_addr];
      rd_ptr  <= rd_addr;
    end
  end

  assign load_out = cmd.emit_sign || cmd.emit_digit;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (load_out) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      text_char <= CHAR_MINUS;
      last_char <= 1'b0;
    end else if (cmd.emit_digit) begin
      text_char <= digit_char(digit_q);
      last_char <= (rd_ptr == '0);
    end
  end

  assign status.div_done = last_step && (quo_w == '0);
  assign status.negative = neg;
  assign status.more     = (rd_ptr != '0);
  assign status.out_free = !out_valid || out_ready;

endmodule

// ===== sv/irt_checker.sv =====
// Port-level assertions for the converter, bound to the top level.
module irt_port_checks (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [irt_pkg::CHAR_W-1:0] text_char,
  input logic                       last_char
);
  import irt_pkg::*;

  // Stalled character holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(text_char) && $stable(last_char))
    else $error("stalled character changed");

  // One number at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a number is in progress");

  // While idle, any character still waiting must close its number
  a_idle_only_after_last: assert property (@(posedge clk) disable iff (rst)
    in_ready && out_valid |-> last_char)
    else $error("idle with an unfinished number");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (text_char == CHAR_MINUS) |-> !last_char)
    else $error("minus sign flagged as last character");

  a_char_set: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (text_char == CHAR_MINUS)
      || (text_char >= CHAR_ZERO && text_char <= CHAR_ZERO + 8'd9)
      || (text_char >= CHAR_LETTER_A && text_char <= CHAR_LETTER_A + 8'd25))
    else $error("character outside digit set");

endmodule

bind integer_to_radix_text irt_port_checks u_irt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (number.valid),
  .in_ready  (number.ready),
  .out_valid (text.valid),
  .out_ready (text.ready),
  .text_char (text.text_char),
  .last_char (text.last_char)
);
